[hdl/dtl_pkg.sv]
// shared types and codes for the double-array trie lookup
package dtl_pkg;

    // operation codes on the input channel
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SYMBOL = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    localparam int BASE_W   = 17;
    localparam int CHECK_W  = 16;
    localparam int INDEX_W  = 16;
    localparam int SYMBOL_W = 8;
    localparam int KEY_W    = 16;
    localparam int ENTRY_W  = BASE_W + CHECK_W;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_SYMBOL,
        KIND_END
    } item_kind_t;

    typedef struct packed {
        item_kind_t            kind;
        logic [INDEX_W-1:0]    entry_index;
        logic [BASE_W-1:0]     base_word;
        logic [CHECK_W-1:0]    check_word;
        logic [SYMBOL_W-1:0]   symbol;
        logic                  symbol_ok;
    } queue_item_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SYM,
        ST_END
    } back_state_t;

endpackage

[hdl/double_array_trie_lookup.sv]
// top level of the double-array trie lookup
//
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   operation, entry_index, base_word, check_word, symbol
//  m_       out  m_valid / m_ready   found, key_index
//
// write beat: ST_RUN alone in the back end; symbol beat: table read in ST_RUN,
// then check and new base in ST_SYM; ST_RUN alone once the walk has failed or
// the index is out of range; end beat: ST_RUN then ST_END, ST_RUN alone when
// no terminator read is needed. the table ram read is registered, and the next
// address is the base just read. after reset all TABLE_DEPTH entries are cleared with s_ready low.
// a 4-beat queue parts front and back; an end beat waits while the result register is full.
module double_array_trie_lookup #(
    parameter int TABLE_DEPTH   = 65536,
    parameter int MAX_KEYS      = 65536,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [dtl_pkg::INDEX_W-1:0]   s_entry_index,
    input  logic signed [dtl_pkg::BASE_W-1:0] s_base_word,
    input  logic [dtl_pkg::CHECK_W-1:0]   s_check_word,
    input  logic [dtl_pkg::SYMBOL_W-1:0]  s_symbol,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [dtl_pkg::KEY_W-1:0]     m_key_index
);
    import dtl_pkg::*;

    back_status_t status;
    queue_item_t  push_item, pop_item;
    logic         push, push_ready, pop_valid, pop;

    dtl_front #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_entry_index (s_entry_index),
        .s_base_word   (s_base_word),
        .s_check_word  (s_check_word),
        .s_symbol      (s_symbol),
        .status        (status),
        .q_ready       (push_ready),
        .q_push        (push),
        .q_item        (push_item)
    );

    dtl_queue #(
        .DEPTH (4)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    dtl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_KEYS    (MAX_KEYS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_item      (pop_item),
        .q_pop       (pop),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_key_index (m_key_index)
    );

endmodule

[hdl/dtl_ram.sv]
// generic single-port ram with registered read
module dtl_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65536
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/dtl_front.sv]
// front end: accepts input beats, classifies them and drops the ones with no effect
module dtl_front #(
    parameter int TABLE_DEPTH   = 65536,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [dtl_pkg::INDEX_W-1:0]   s_entry_index,
    input  logic [dtl_pkg::BASE_W-1:0]    s_base_word,
    input  logic [dtl_pkg::CHECK_W-1:0]   s_check_word,
    input  logic [dtl_pkg::SYMBOL_W-1:0]  s_symbol,
    input  dtl_pkg::back_status_t         status,
    input  logic                          q_ready,
    output logic                          q_push,
    output dtl_pkg::queue_item_t          q_item
);
    import dtl_pkg::*;

    logic drop;

    always_comb begin
        q_item.entry_index = s_entry_index;
        q_item.base_word   = s_base_word;
        q_item.check_word  = s_check_word;
        q_item.symbol      = s_symbol;
        q_item.symbol_ok   = 32'(s_symbol) < 32'(ALPHABET_SIZE);
        q_item.kind        = KIND_WRITE;
        drop               = 1'b0;
        case (s_operation)
            OP_WRITE: begin
                q_item.kind = KIND_WRITE;
                // writes beyond the table are taken and forgotten
                drop        = !(32'(s_entry_index) < 32'(TABLE_DEPTH));
            end
            OP_SYMBOL: begin
                q_item.kind = KIND_SYMBOL;
            end
            OP_END: begin
                q_item.kind = KIND_END;
            end
            default: begin
                drop = 1'b1;
            end
        endcase
    end

    assign s_ready = q_ready && !status.clearing;
    assign q_push  = s_valid && s_ready && !drop;

endmodule

[hdl/dtl_queue.sv]
// short fifo of classified items between front and back
module dtl_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  dtl_pkg::queue_item_t  push_item,
    output logic                  push_ready,
    output logic                  pop_valid,
    output dtl_pkg::queue_item_t  pop_item,
    input  logic                  pop
);
    import dtl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    queue_item_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/dtl_back.sv]
// back end: clears the table, walks transitions and delivers results
module dtl_back #(
    parameter int TABLE_DEPTH = 65536,
    parameter int MAX_KEYS    = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  dtl_pkg::queue_item_t          q_item,
    output logic                          q_pop,
    output dtl_pkg::back_status_t         status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [dtl_pkg::KEY_W-1:0]     m_key_index
);
    import dtl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    back_state_t        state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [BASE_W-1:0]  cur_base_reg, cur_base_next;
    logic [BASE_W-1:0]  base0_reg, base0_next;
    logic               at_start_reg, at_start_next;
    logic               failed_reg, failed_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [KEY_W-1:0]   m_key_reg, m_key_next;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [BASE_W-1:0]  rd_base;
    logic [CHECK_W-1:0] rd_check;

    logic [BASE_W-1:0]  walk_b;
    logic [BASE_W:0]    trans_p;
    logic               p_ok, b_ok, out_free, result_set;
    logic [KEY_W-1:0]   leaf_key;

    dtl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_base  = ram_rdata[ENTRY_W-1:CHECK_W];
    assign rd_check = ram_rdata[CHECK_W-1:0];
    assign leaf_key = ~rd_base[KEY_W-1:0];

    // base the walk stands on, base[0] at the start of a text
    assign walk_b  = at_start_reg ? base0_reg : cur_base_reg;
    assign trans_p = {walk_b[BASE_W-1], walk_b} + {{(BASE_W+1-SYMBOL_W){1'b0}}, q_item.symbol};
    assign p_ok    = !trans_p[BASE_W] && (32'(trans_p[BASE_W-1:0]) < 32'(TABLE_DEPTH));
    assign b_ok    = !walk_b[BASE_W-1] && (32'(walk_b[BASE_W-2:0]) < 32'(TABLE_DEPTH));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_base_next = cur_base_reg;
        base0_next    = base0_reg;
        at_start_next = at_start_reg;
        failed_next   = failed_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_found_next  = m_found_reg;
        m_key_next    = m_key_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = AW'(32'(trans_p[BASE_W-1:0]));
        ram_wdata     = {q_item.base_word, q_item.check_word};
        result_set    = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TABLE_DEPTH - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (q_valid && (q_item.kind != KIND_END || out_free)) begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        KIND_WRITE: begin
                            ram_we   = 1'b1;
                            ram_addr = AW'(32'(q_item.entry_index));
                            if (q_item.entry_index == '0) begin
                                base0_next = q_item.base_word;
                            end
                        end
                        KIND_SYMBOL: begin
                            at_start_next = 1'b0;
                            cur_base_next = walk_b;
                            if (!failed_reg) begin
                                if (!q_item.symbol_ok || !p_ok) begin
                                    failed_next = 1'b1;
                                end else begin
                                    state_next = ST_SYM;
                                end
                            end
                        end
                        KIND_END: begin
                            ram_addr = AW'(32'(walk_b[BASE_W-2:0]));
                            if (failed_reg || !b_ok) begin
                                result_set    = 1'b1;
                                m_found_next  = 1'b0;
                                m_key_next    = '0;
                                cur_base_next = '0;
                                at_start_next = 1'b1;
                                failed_next   = 1'b0;
                            end else begin
                                cur_base_next = walk_b;
                                at_start_next = 1'b0;
                                state_next    = ST_END;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SYM: begin
                if ({1'b0, rd_check} == cur_base_reg) begin
                    cur_base_next = rd_base;
                end else begin
                    failed_next = 1'b1;
                end
                state_next = ST_RUN;
            end
            ST_END: begin
                result_set = 1'b1;
                // terminator slot: owned by this base and holding a leaf
                if ({1'b0, rd_check} == cur_base_reg && rd_base[BASE_W-1]
                    && (32'(leaf_key) < 32'(MAX_KEYS))) begin
                    m_found_next = 1'b1;
                    m_key_next   = leaf_key;
                end else begin
                    m_found_next = 1'b0;
                    m_key_next   = '0;
                end
                cur_base_next = '0;
                at_start_next = 1'b1;
                failed_next   = 1'b0;
                state_next    = ST_RUN;
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        if (result_set) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            cur_base_reg <= '0;
            base0_reg    <= '0;
            at_start_reg <= 1'b1;
            failed_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            cur_base_reg <= cur_base_next;
            base0_reg    <= base0_next;
            at_start_reg <= at_start_next;
            failed_reg   <= failed_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_key_reg   <= m_key_next;
    end

    assign status.clearing = state_reg == ST_CLEAR;
    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_key_index     = m_key_reg;

    a_sym_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SYM) |-> $past(q_pop && q_item.kind == KIND_SYMBOL))
        else $error("symbol read stage without a popped symbol");

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        result_set |-> out_free)
        else $error("result written over an undelivered beat");

    a_no_pop_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("item popped during table clear");

    a_no_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SYM || state_reg == ST_END) |-> !ram_we)
        else $error("table write while a read result is pending");

    a_found_has_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_key_reg == '0))
        else $error("not-found result carries a key index");

endmodule
